// ===== hdl/bprc_pkg.sv =====
// Shared types, constants and helper functions for the bond pair rule check block.
// Depends on nothing; bprc_dist and bond_pair_rule_check import it.
package bprc_pkg;

  localparam int RULES_DEF       = 16;
  localparam int COORD_BITS      = 24;
  localparam int MAG_W           = 24;            // saturated |difference| width
  localparam int DIFF_SAT        = 2 ** 23;
  localparam int DIFF_W          = COORD_BITS + 1;
  localparam int EXT_W           = (DIFF_W > MAG_W) ? DIFF_W : MAG_W;
  localparam int SQ_W            = 2 * MAG_W;     // squared distance width
  localparam int ELEM_W          = 8;
  localparam int DIST_W          = 23;
  localparam int CNT_W           = 7;
  localparam int RCNT_W          = 5;
  localparam int APB_AW          = 3;
  localparam int APB_DW          = 32;
  localparam logic [CNT_W-1:0] MAX_BONDS_RST = 7'd10;

  // Register index, taken from paddr[2]
  localparam logic REG_RULE_COUNT = 1'b0;
  localparam logic REG_MAX_BONDS  = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE_RULE = 2'd0,
    OP_TEST_NEW   = 2'd1,
    OP_TEST_SAME  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIST,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                           op;
    logic [3:0]                    rule_index;
    logic signed [ELEM_W-1:0]      elem_a;
    logic signed [ELEM_W-1:0]      elem_b;
    logic [DIST_W-1:0]             min_dist;
    logic [DIST_W-1:0]             max_dist;
    logic signed [COORD_BITS-1:0]  ax;
    logic signed [COORD_BITS-1:0]  ay;
    logic signed [COORD_BITS-1:0]  az;
    logic signed [COORD_BITS-1:0]  bx;
    logic signed [COORD_BITS-1:0]  by;
    logic signed [COORD_BITS-1:0]  bz;
  } bprc_in_t;

  typedef struct packed {
    logic             bonded;
    logic             rule_found;
    logic             clamped;
    logic [CNT_W-1:0] bond_count;
  } bprc_out_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] e1;
    logic signed [ELEM_W-1:0] e2;
    logic [DIST_W-1:0]        dmin;
    logic [DIST_W-1:0]        dmax;
  } rule_t;

  // |a - b|, saturated at 2^23 (above any legal limit, so decisions are unchanged)
  function automatic logic [MAG_W-1:0] sat_mag(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        m;
    logic [EXT_W-1:0]         me;
    d  = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    m  = d[DIFF_W-1] ? $unsigned(-d) : $unsigned(d);
    me = EXT_W'(m);
    return (me > EXT_W'(DIFF_SAT)) ? MAG_W'(DIFF_SAT) : me[MAG_W-1:0];
  endfunction

endpackage

// ===== hdl/bprc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the rule table.
module bprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/bprc_dist.sv =====
// Squared distance and limit compare on one shared 24x24 multiplier.
// Depends on bprc_pkg.
module bprc_dist
  import bprc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bprc_in_t          item_i,
  input  logic [DIST_W-1:0] lo_i,
  input  logic [DIST_W-1:0] hi_i,
  output logic              done_o,
  output logic              in_range_o
);

  localparam logic [2:0] STEP_LAST = 3'd7;

  logic             busy_q, busy_d;
  logic [2:0]       step_q, step_d;
  logic [2:0]       acc_step;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic [SQ_W-1:0]  prod_q;
  logic [SQ_W-1:0]  d2_q, lo2_q, hi2_q;

  // Stage A: operand select and |diff| (steps 0..4), B: square (1..5), C: accumulate (2..6)
  always_comb begin
    case (step_q)
      3'd0:    mag_d = sat_mag(item_i.ax, item_i.bx);
      3'd1:    mag_d = sat_mag(item_i.ay, item_i.by);
      3'd2:    mag_d = sat_mag(item_i.az, item_i.bz);
      3'd3:    mag_d = MAG_W'(lo_i);
      3'd4:    mag_d = MAG_W'(hi_i);
      default: mag_d = '0;
    endcase
  end

  assign acc_step = step_q - 3'd2;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      if (step_q == STEP_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    prod_q <= mag_q * mag_q;
    if (busy_q && step_q >= 3'd2 && step_q <= 3'd6) begin
      case (acc_step)
        3'd0:    d2_q  <= prod_q;
        3'd1,
        3'd2:    d2_q  <= d2_q + prod_q;
        3'd3:    lo2_q <= prod_q;
        3'd4:    hi2_q <= prod_q;
        default: d2_q  <= d2_q;
      endcase
    end
  end

  assign done_o     = busy_q && (step_q == STEP_LAST);
  assign in_range_o = (d2_q > lo2_q) && (d2_q < hi2_q);

endmodule

// ===== hdl/bond_pair_rule_check.sv =====
// Top level of the bond pair rule check: rule table search sequencer, counters, APB registers.
// Depends on bprc_pkg, bprc_ram and bprc_dist.
//
// Usage: requests enter on in_valid_i/in_stall_o/in_data_i and results leave on
// out_valid_o/out_stall_i/out_data_o, one result per request, in order. A request
// either writes a rule (op 0) or tests an atom pair (op 1 new first atom, op 2 same).
// A test searches the rule table memory in index order, one entry per cycle through
// its single read port, then, if the first match has valid limits, runs the squared
// distance on one shared multiplier. Writes, unused ops, clamped tests and an empty
// table go straight to the done state, as does a test with no match among the first
// rule_count entries. One request is in flight at a time; in_stall_o is high from
// accept until the result is moved into the output register, so the next request
// can be taken while a result waits there. If the receiver stalls with the output
// register full, the finished result waits in the block and inputs stay stalled.
// Reset clears the bond counter and the registers (rule_count 0, max_bonds_per_atom
// 10); the rule table is not cleared and entries must be written before rule_count
// covers them. Registers are at byte 0 and 4 of the APB port; the user must change
// them only while the block is idle, as the block itself does not enforce this.
module bond_pair_rule_check
  import bprc_pkg::*;
#(
  parameter int RULES = RULES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bprc_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bprc_out_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int IW   = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int NW   = $clog2(RULES + 1);
  localparam int CNTW = (NW > RCNT_W) ? NW : RCNT_W;

  state_e state_q, state_d;

  logic [RCNT_W-1:0] rule_count_q;
  logic [CNT_W-1:0]  max_bonds_q;
  logic [CNT_W-1:0]  atom_bonds_q;
  bprc_in_t          item_q;
  logic [CNTW-1:0]   issue_q;
  logic              pend_q;
  logic [DIST_W-1:0] lo_q, hi_q;
  logic              bonded_q, found_q, clamped_q;
  logic              out_valid_q;
  bprc_out_t         out_q;

  logic              accept, cfg_wr;
  logic [CNTW-1:0]   n_rules, rc_ext;
  logic [CNT_W-1:0]  cnt_eff;
  logic              is_test, clamp_now;
  logic              ram_we, ram_re;
  rule_t             ram_wdata, rule_rd;
  logic              hit, good_limits, not_found;
  logic              dist_start, dist_done, dist_in_range;
  logic              out_load;
  logic              m11, m12, m21, m22;

  assign accept  = in_valid_i && !in_stall_o;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  assign rc_ext  = CNTW'(rule_count_q);
  assign n_rules = (rc_ext > CNTW'(RULES)) ? CNTW'(RULES) : rc_ext;

  assign is_test   = (in_data_i.op == OP_TEST_NEW) || (in_data_i.op == OP_TEST_SAME);
  assign cnt_eff   = (in_data_i.op == OP_TEST_NEW) ? '0 : atom_bonds_q;
  assign clamp_now = cnt_eff >= max_bonds_q;

  // Rule table
  assign ram_we    = accept && (in_data_i.op == OP_WRITE_RULE) &&
                     (CNTW'(in_data_i.rule_index) < CNTW'(RULES));
  assign ram_wdata = '{e1: in_data_i.elem_a, e2: in_data_i.elem_b,
                       dmin: in_data_i.min_dist, dmax: in_data_i.max_dist};

  bprc_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (RULES),
    .AW    (IW)
  ) u_rules (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IW'(in_data_i.rule_index)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (issue_q[IW-1:0]),
    .rdata_o (rule_rd)
  );

  // Element match in either order, negative rule element is a wildcard
  assign m11 = rule_rd.e1[ELEM_W-1] || (item_q.elem_a == rule_rd.e1);
  assign m12 = rule_rd.e1[ELEM_W-1] || (item_q.elem_b == rule_rd.e1);
  assign m21 = rule_rd.e2[ELEM_W-1] || (item_q.elem_a == rule_rd.e2);
  assign m22 = rule_rd.e2[ELEM_W-1] || (item_q.elem_b == rule_rd.e2);

  assign hit         = pend_q && ((m11 && m22) || (m12 && m21));
  assign good_limits = (rule_rd.dmax != '0) && (rule_rd.dmax >= rule_rd.dmin);
  assign not_found   = !pend_q && (issue_q >= n_rules);

  bprc_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dist_start),
    .item_i     (item_q),
    .lo_i       (lo_q),
    .hi_i       (hi_q),
    .done_o     (dist_done),
    .in_range_o (dist_in_range)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_test && !clamp_now && (n_rules != '0)) begin
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_d = good_limits ? ST_DIST : ST_DONE;
        end else if (not_found) begin
          state_d = ST_DONE;
        end
      end
      ST_DIST: begin
        if (dist_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    dist_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_SEARCH: begin
        ram_re     = !hit && (issue_q < n_rules);
        dist_start = hit && good_limits;
      end
      ST_DIST:   ;
      ST_DONE:   out_load = !out_valid_q || !out_stall_i;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rule_count_q <= '0;
      max_bonds_q  <= MAX_BONDS_RST;
      atom_bonds_q <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= ram_re;
      if (cfg_wr) begin
        case (paddr[2])
          REG_RULE_COUNT: rule_count_q <= pwdata[RCNT_W-1:0];
          REG_MAX_BONDS:  max_bonds_q  <= pwdata[CNT_W-1:0];
          default:        ;
        endcase
      end
      if (accept && is_test) begin
        atom_bonds_q <= cnt_eff;
      end else if (dist_done && dist_in_range) begin
        atom_bonds_q <= atom_bonds_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q    <= in_data_i;
      issue_q   <= '0;
      bonded_q  <= 1'b0;
      found_q   <= 1'b0;
      clamped_q <= is_test && clamp_now;
    end
    if (ram_re) begin
      issue_q <= issue_q + CNTW'(1);
    end
    if (hit && state_q == ST_SEARCH) begin
      found_q <= 1'b1;
      lo_q    <= rule_rd.dmin;
      hi_q    <= rule_rd.dmax;
    end
    if (dist_done && dist_in_range) begin
      bonded_q <= 1'b1;
    end
    if (out_load) begin
      out_q <= '{bonded: bonded_q, rule_found: found_q, clamped: clamped_q,
                 bond_count: atom_bonds_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    case (paddr[2])
      REG_RULE_COUNT: prdata = APB_DW'(rule_count_q);
      REG_MAX_BONDS:  prdata = APB_DW'(max_bonds_q);
      default:        prdata = '0;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_bond_needs_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.bonded && (!out_data_o.rule_found || out_data_o.clamped)))
    else $error("bond reported without a matching rule or while clamped");

  a_clamp_no_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clamped |-> !out_data_o.rule_found)
    else $error("clamped result also reports a rule");

  a_dist_in_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_done |-> (state_q == ST_DIST))
    else $error("distance unit finished outside of distance state");

endmodule
